// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dcc_pkg.sv =====
package dcc_pkg;

  // input transaction
  typedef struct packed {
    logic       item_kind;
    logic [7:0] code;
    logic [7:0] data;
  } cmd_item_t;

  // result transaction
  typedef struct packed {
    logic [6:0]        motor_duty;
    logic              motor_reverse;
    logic              brake_on;
    logic [6:0]        servo_position;
    logic              servo_changed;
    logic signed [7:0] steer_offset;
    logic              steer_valid;
    logic [1:0]        gain_select;
    logic [7:0]        gain_raw;
    logic              echo_valid;
    logic [7:0]        echo_code;
  } result_t;

  // item kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // command codes
  localparam logic [7:0] CODE_MOVE   = 8'h01;
  localparam logic [7:0] CODE_MODE   = 8'h02;
  localparam logic [7:0] CODE_OFFSET = 8'h10;
  localparam logic [7:0] CODE_GAIN_P = 8'h11;
  localparam logic [7:0] CODE_GAIN_I = 8'h12;
  localparam logic [7:0] CODE_GAIN_D = 8'h20;
  localparam logic [7:0] CODE_SPEED  = 8'h50;
  localparam logic [7:0] CODE_STOP   = 8'hFF;

  // mode bytes
  localparam logic [7:0] MODE_MANUAL = 8'd0;
  localparam logic [7:0] MODE_AUTO   = 8'd1;

  // stop / auto data bytes
  localparam logic [7:0] STOP_START  = 8'd0;
  localparam logic [7:0] AUTO_START  = 8'd1;

  // gain selects
  localparam logic [1:0] GAIN_NONE = 2'd0;
  localparam logic [1:0] GAIN_P    = 2'd1;
  localparam logic [1:0] GAIN_I    = 2'd2;
  localparam logic [1:0] GAIN_D    = 2'd3;

  // move packet bits
  localparam int MOVE_BIT_REV   = 2;
  localparam int MOVE_BIT_RIGHT = 3;
  localparam int MOVE_BIT_LEFT  = 4;
  localparam int MOVE_BIT_BRAKE = 5;
  localparam int MOVE_BIT_FWD   = 6;

  // servo setpoints
  localparam logic [6:0] SERVO_LEFT   = 7'd0;
  localparam logic [6:0] SERVO_CENTER = 7'd50;
  localparam logic [6:0] SERVO_RIGHT  = 7'd100;

  // throttle scaling
  localparam int PWM_TOP       = 127;
  localparam int THR_MIN       = 40;
  localparam int THR_MAX       = 100;
  localparam int DUTY_SHIFT    = 16;
  localparam int DUTY_MUL      = ((PWM_TOP << DUTY_SHIFT) + 99) / 100;
  localparam logic [6:0] DUTY_LIMIT = 7'd127;

  // offset zero point
  localparam logic [7:0] OFFSET_CENTER = 8'd63;

  // stop profile
  localparam int SPEED_REF     = 50;
  localparam int STOP_T1_MS    = 500;
  localparam int STOP_T1_STEP  = 24;
  localparam int STOP_T2_MS    = 1200;
  localparam int STOP_T2_STEP  = 60;
  localparam logic [15:0] STOP_T1_BASE = 16'(STOP_T1_MS + STOP_T1_STEP * SPEED_REF);
  localparam logic [15:0] STOP_T2_BASE = 16'(STOP_T2_MS + STOP_T2_STEP * SPEED_REF);
  localparam logic [7:0] STOP_THR_HIGH = 8'd50;
  localparam logic [7:0] STOP_THR_LOW  = 8'd30;

  // reset values
  localparam logic [7:0] SPEED_RESET = 8'd60;

endpackage

// ===== hw/rtl/dcc_throttle.sv =====
module dcc_throttle (
  input  logic [7:0] percent,
  output logic [6:0] duty
);
  import dcc_pkg::*;

  logic [6:0]  pct_clamped;
  logic [23:0] prod;
  logic [7:0]  quot;

  // dead band below the minimum, clamp at full throttle
  always_comb begin
    if (percent < 8'(THR_MIN)) begin
      pct_clamped = 7'd0;
    end else if (percent > 8'(THR_MAX)) begin
      pct_clamped = 7'(THR_MAX);
    end else begin
      pct_clamped = percent[6:0];
    end
  end

  // percent * top / 100 by reciprocal multiply
  assign prod = 24'(pct_clamped) * 24'(DUTY_MUL);
  assign quot = prod[DUTY_SHIFT +: 8];

  // duty register is 7 bits wide
  assign duty = (quot > 8'(DUTY_LIMIT)) ? DUTY_LIMIT : quot[6:0];

endmodule

// ===== hw/rtl/dcc_core.sv =====
module dcc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  dcc_pkg::cmd_item_t item,
  output dcc_pkg::result_t   result
);
  import dcc_pkg::*;

  logic [7:0]  speed_setting, speed_setting_next;
  logic [7:0]  mode_byte, mode_byte_next;
  logic        stop_active, stop_active_next;
  logic        auto_enabled, auto_enabled_next;
  logic [31:0] elapsed_ms, elapsed_ms_next;
  logic [6:0]  duty_reg, duty_reg_next;
  logic        reverse_reg, reverse_reg_next;
  logic        brake_reg, brake_reg_next;
  logic [6:0]  servo_reg, servo_reg_next;

  logic        thr_en;
  logic [7:0]  thr_percent;
  logic        thr_dir;
  logic [6:0]  thr_duty;
  logic        brake_set;
  logic [31:0] elapsed_inc;
  logic [15:0] stop_t1;
  logic [15:0] stop_t2;
  result_t     res;

  dcc_throttle u_throttle (
    .percent (thr_percent),
    .duty    (thr_duty)
  );

  // saturating tick counter and wrapped stop thresholds
  assign elapsed_inc = (&elapsed_ms) ? elapsed_ms : elapsed_ms + 32'd1;
  assign stop_t1 = STOP_T1_BASE - 16'(STOP_T1_STEP * int'(speed_setting));
  assign stop_t2 = STOP_T2_BASE - 16'(STOP_T2_STEP * int'(speed_setting));

  // command decode and state update
  always_comb begin
    speed_setting_next = speed_setting;
    mode_byte_next     = mode_byte;
    stop_active_next   = stop_active;
    auto_enabled_next  = auto_enabled;
    elapsed_ms_next    = elapsed_ms;
    servo_reg_next     = servo_reg;
    thr_en             = 1'b0;
    thr_percent        = speed_setting;
    thr_dir            = 1'b0;
    brake_set          = 1'b0;
    res                = '0;

    if (item.item_kind == KIND_TICK) begin
      elapsed_ms_next = elapsed_inc;
      if (stop_active) begin
        thr_en = 1'b1;
        if (elapsed_inc < {16'd0, stop_t1}) begin
          thr_percent = STOP_THR_HIGH;
        end else if (elapsed_inc < {16'd0, stop_t2}) begin
          thr_percent = STOP_THR_LOW;
        end else begin
          thr_percent = 8'd0;
        end
      end
    end else begin
      case (item.code)
        CODE_MODE: begin
          mode_byte_next = item.data;
          if (item.data == MODE_MANUAL) begin
            stop_active_next = 1'b0;
          end else if (item.data == MODE_AUTO) begin
            stop_active_next  = 1'b1;
            auto_enabled_next = 1'b0;
          end
          thr_en      = 1'b1;
          thr_percent = 8'd0;
          brake_set   = 1'b1;
        end
        CODE_SPEED: begin
          speed_setting_next = item.data;
        end
        CODE_STOP: begin
          if (item.data == STOP_START) begin
            stop_active_next = 1'b1;
            elapsed_ms_next  = 32'd0;
          end else if (item.data == AUTO_START) begin
            auto_enabled_next = 1'b1;
            stop_active_next  = 1'b0;
          end
        end
        CODE_MOVE: begin
          if (mode_byte == MODE_MANUAL && !stop_active) begin
            if (item.data[MOVE_BIT_BRAKE]) begin
              brake_set = 1'b1;
            end else if (item.data[MOVE_BIT_FWD]) begin
              thr_en = 1'b1;
            end else if (item.data[MOVE_BIT_REV]) begin
              thr_en  = 1'b1;
              thr_dir = 1'b1;
            end else begin
              thr_en      = 1'b1;
              thr_percent = 8'd0;
            end
            if (item.data[MOVE_BIT_LEFT]) begin
              servo_reg_next = SERVO_LEFT;
            end else if (item.data[MOVE_BIT_RIGHT]) begin
              servo_reg_next = SERVO_RIGHT;
            end else begin
              servo_reg_next = SERVO_CENTER;
            end
            res.servo_changed = 1'b1;
          end
        end
        CODE_OFFSET: begin
          if (mode_byte == MODE_AUTO) begin
            res.steer_valid = 1'b1;
            if (item.data != 8'd0) begin
              res.steer_offset = item.data - OFFSET_CENTER;
              if (!stop_active && auto_enabled) begin
                thr_en = 1'b1;
              end
            end
          end
        end
        CODE_GAIN_P: begin
          res.gain_select = GAIN_P;
          res.gain_raw    = item.data;
        end
        CODE_GAIN_I: begin
          res.gain_select = GAIN_I;
          res.gain_raw    = item.data;
        end
        CODE_GAIN_D: begin
          res.gain_select = GAIN_D;
          res.gain_raw    = item.data;
        end
        default: begin
          res.echo_valid = 1'b1;
          res.echo_code  = item.code;
        end
      endcase
    end
  end

  // motor registers follow the throttle request, brake wins last
  always_comb begin
    duty_reg_next    = duty_reg;
    reverse_reg_next = reverse_reg;
    brake_reg_next   = brake_reg;
    if (thr_en) begin
      duty_reg_next    = thr_duty;
      reverse_reg_next = thr_dir;
      brake_reg_next   = 1'b0;
    end
    if (brake_set) begin
      brake_reg_next = 1'b1;
    end
  end

  // result carries the updated motor and servo state
  always_comb begin
    result                = res;
    result.motor_duty     = duty_reg_next;
    result.motor_reverse  = reverse_reg_next;
    result.brake_on       = brake_reg_next;
    result.servo_position = servo_reg_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_setting <= SPEED_RESET;
      mode_byte     <= MODE_MANUAL;
      stop_active   <= 1'b0;
      auto_enabled  <= 1'b0;
      elapsed_ms    <= 32'd0;
      duty_reg      <= 7'd0;
      reverse_reg   <= 1'b0;
      brake_reg     <= 1'b0;
      servo_reg     <= SERVO_CENTER;
    end else if (step) begin
      speed_setting <= speed_setting_next;
      mode_byte     <= mode_byte_next;
      stop_active   <= stop_active_next;
      auto_enabled  <= auto_enabled_next;
      elapsed_ms    <= elapsed_ms_next;
      duty_reg      <= duty_reg_next;
      reverse_reg   <= reverse_reg_next;
      brake_reg     <= brake_reg_next;
      servo_reg     <= servo_reg_next;
    end
  end

endmodule

// ===== hw/rtl/drive_command_controller.sv =====
// channel | direction | handshake            | payload
// cmd     | in        | cmd_valid, cmd_stall | cmd (cmd_item_t)
// res     | out       | res_valid, res_stall | res (result_t)
//
// One result per transaction, one transaction per cycle sustained while res_stall is low.
// A transaction passes two registers: input register, then decode and state update into
// the result register.
// Reset (rst, synchronous) empties both registers and loads the state defaults.
// A stalled result holds the input register; cmd_stall rises only while the
// input register is full and cannot move forward.
`include "assert_macros.svh"

module drive_command_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  dcc_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output dcc_pkg::result_t   res
);
  import dcc_pkg::*;

  logic      in_valid;
  cmd_item_t in_item;
  logic      advance;
  logic      cmd_take;
  result_t   core_result;

  // pipeline moves when the result register is free or being drained
  assign advance   = in_valid && (!res_valid || !res_stall);
  assign cmd_stall = in_valid && !advance;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      in_item <= cmd;
    end
  end

  dcc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_result;
    end
  end

  // checks
  `ASSERT_NEXT(a_advance_fills, clk, rst, advance, res_valid,
    "result lost after advance")
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, res_valid && res_stall && in_valid,
    cmd_stall, "input taken while pipeline blocked")
  `ASSERT_IMPLIES(a_servo_range, clk, rst, res_valid,
    res.servo_position <= SERVO_RIGHT, "servo setpoint out of range")
  `ASSERT_IMPLIES(a_offset_quiet, clk, rst, res_valid && !res.steer_valid,
    res.steer_offset == 8'sd0, "offset without steer_valid")

endmodule

// ===== bench/tb_drive_command_controller.sv =====
`timescale 1ns / 1ps

module tb_drive_command_controller;
  import dcc_pkg::*;

  // run length and limits
  localparam int unsigned RANDOM_ITEMS   = 1800;
  localparam int unsigned CALM_TAIL      = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PRINT_LIMIT    = 50;

  // throttle scaling and stop profile
  localparam int unsigned MIN_PCT   = 40;
  localparam int unsigned MAX_PCT   = 100;
  localparam int unsigned DUTY_TOP  = 127;
  localparam int unsigned T1_ORIGIN = 1700;  // 500 ms at speed 50
  localparam int unsigned T1_SLOPE  = 24;
  localparam int unsigned T2_ORIGIN = 4200;  // 1200 ms at speed 50
  localparam int unsigned T2_SLOPE  = 60;
  localparam int unsigned HIGH_PCT  = 50;
  localparam int unsigned LOW_PCT   = 30;
  localparam logic [7:0]  OFFSET_ZERO = 8'd63;

  // values outside the decoded sets
  localparam logic [7:0] MODE_UNDEFINED   = 8'd7;
  localparam logic [7:0] STOP_NOTHING     = 8'd2;
  localparam logic [7:0] CODE_UNUSED_LOW  = 8'h00;
  localparam logic [7:0] CODE_UNUSED_HIGH = 8'hFE;

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_item_t cmd;
  logic      res_valid;
  logic      res_stall = 1'b0;
  result_t   res;

  drive_command_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #2 clk = ~clk;

  // mirror of the controller state, starting at the reset defaults
  logic [7:0]  m_speed   = 8'd60;
  logic [7:0]  m_mode    = MODE_MANUAL;
  logic        m_stop    = 1'b0;
  logic        m_auto    = 1'b0;
  logic [31:0] m_elapsed = 32'd0;
  logic [6:0]  m_duty    = 7'd0;
  logic        m_reverse = 1'b0;
  logic        m_brake   = 1'b0;
  logic [6:0]  m_servo   = 7'd50;

  result_t     expected_results[$];
  result_t     want;
  int unsigned fail_count   = 0;
  int unsigned sent_count   = 0;
  int unsigned idle_pct     = 20;
  int unsigned stall_left   = 0;
  int unsigned stuck_cycles = 0;

  // throttle request: dead band, clamp, scale to duty, release brake
  function automatic void set_throttle(int unsigned pct, logic dir);
    int unsigned d;
    if (pct < MIN_PCT) pct = 0;
    if (pct > MAX_PCT) pct = MAX_PCT;
    m_brake   = 1'b0;
    m_reverse = dir;
    d = pct * DUTY_TOP / 100;
    if (d > DUTY_TOP) d = DUTY_TOP;
    m_duty = d[6:0];
  endfunction

  // next outputs of the controller for one transaction, updating the mirror
  function automatic result_t predict_drive(cmd_item_t it);
    result_t     r;
    logic [15:0] t1;
    logic [15:0] t2;
    r = '0;
    if (it.item_kind == KIND_TICK) begin
      if (m_elapsed != 32'hFFFF_FFFF) m_elapsed = m_elapsed + 32'd1;
      // timed stop profile, thresholds wrap to 16 bits
      if (m_stop) begin
        t1 = 16'(T1_ORIGIN - T1_SLOPE * m_speed);
        t2 = 16'(T2_ORIGIN - T2_SLOPE * m_speed);
        if (m_elapsed < 32'(t1)) set_throttle(HIGH_PCT, 1'b0);
        else if (m_elapsed < 32'(t2)) set_throttle(LOW_PCT, 1'b0);
        else set_throttle(0, 1'b0);
      end
    end else begin
      case (it.code)
        CODE_MODE: begin
          m_mode = it.data;
          if (it.data == MODE_MANUAL) begin
            m_stop = 1'b0;
          end else if (it.data == MODE_AUTO) begin
            m_stop = 1'b1;
            m_auto = 1'b0;
          end
          set_throttle(0, 1'b0);
          m_brake = 1'b1;
        end
        CODE_SPEED: m_speed = it.data;
        CODE_STOP: begin
          if (it.data == STOP_START) begin
            m_stop    = 1'b1;
            m_elapsed = 32'd0;
          end else if (it.data == AUTO_START) begin
            m_auto = 1'b1;
            m_stop = 1'b0;
          end
        end
        CODE_MOVE: begin
          if (m_mode == MODE_MANUAL && !m_stop) begin
            if (it.data[MOVE_BIT_BRAKE]) m_brake = 1'b1;
            else if (it.data[MOVE_BIT_FWD]) set_throttle(m_speed, 1'b0);
            else if (it.data[MOVE_BIT_REV]) set_throttle(m_speed, 1'b1);
            else set_throttle(0, 1'b0);
            if (it.data[MOVE_BIT_LEFT]) m_servo = SERVO_LEFT;
            else if (it.data[MOVE_BIT_RIGHT]) m_servo = SERVO_RIGHT;
            else m_servo = SERVO_CENTER;
            r.servo_changed = 1'b1;
          end
        end
        CODE_OFFSET: begin
          if (m_mode == MODE_AUTO) begin
            r.steer_valid = 1'b1;
            if (it.data != 8'd0) begin
              r.steer_offset = it.data - OFFSET_ZERO;
              if (!m_stop && m_auto) set_throttle(m_speed, 1'b0);
            end
          end
        end
        CODE_GAIN_P: begin
          r.gain_select = GAIN_P;
          r.gain_raw    = it.data;
        end
        CODE_GAIN_I: begin
          r.gain_select = GAIN_I;
          r.gain_raw    = it.data;
        end
        CODE_GAIN_D: begin
          r.gain_select = GAIN_D;
          r.gain_raw    = it.data;
        end
        default: begin
          r.echo_valid = 1'b1;
          r.echo_code  = it.code;
        end
      endcase
    end
    r.motor_duty     = m_duty;
    r.motor_reverse  = m_reverse;
    r.brake_on       = m_brake;
    r.servo_position = m_servo;
    return r;
  endfunction

  // one line per mismatch, printing capped
  task automatic report_mismatch(string msg);
    if (fail_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("motor_duty", res.motor_duty, want.motor_duty);
        check_field("motor_reverse", res.motor_reverse, want.motor_reverse);
        check_field("brake_on", res.brake_on, want.brake_on);
        check_field("servo_position", res.servo_position, want.servo_position);
        check_field("servo_changed", res.servo_changed, want.servo_changed);
        check_field("steer_offset", res.steer_offset, want.steer_offset);
        check_field("steer_valid", res.steer_valid, want.steer_valid);
        check_field("gain_select", res.gain_select, want.gain_select);
        check_field("gain_raw", res.gain_raw, want.gain_raw);
        check_field("echo_valid", res.echo_valid, want.echo_valid);
        check_field("echo_code", res.echo_code, want.echo_code);
      end
    end
  end

  // result side stall bursts, started at random with the idling percentage
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      res_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // present one transaction, wait for acceptance, queue its expected result
  task automatic send_item(cmd_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= it;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    expected_results.push_back(predict_drive(it));
    sent_count++;
  endtask

  task automatic send_packet(logic [7:0] op, logic [7:0] arg);
    send_item('{item_kind: KIND_PACKET, code: op, data: arg});
  endtask

  // tick with junk in the ignored fields
  task automatic send_tick();
    send_item('{item_kind: KIND_TICK, code: 8'($urandom), data: 8'($urandom)});
  endtask

  // hold the sender until every expected result is back
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0: return CODE_MOVE;
      1: return CODE_MODE;
      2: return CODE_OFFSET;
      3: return CODE_GAIN_P;
      4: return CODE_GAIN_I;
      5: return CODE_GAIN_D;
      6: return CODE_SPEED;
      7: return CODE_STOP;
      default: return 8'($urandom);
    endcase
  endfunction

  // defaults seen on idle ticks
  task automatic test_reset_defaults();
    send_tick();
    send_tick();
  endtask

  // move bits: drive direction, brake priority, steering priority
  task automatic test_manual_moves();
    send_packet(CODE_MOVE, 8'(1 << MOVE_BIT_FWD));
    send_packet(CODE_MOVE, 8'((1 << MOVE_BIT_REV) | (1 << MOVE_BIT_LEFT)));
    send_packet(CODE_MOVE,
                8'((1 << MOVE_BIT_BRAKE) | (1 << MOVE_BIT_FWD) | (1 << MOVE_BIT_RIGHT)));
    send_packet(CODE_MOVE, 8'((1 << MOVE_BIT_LEFT) | (1 << MOVE_BIT_RIGHT)));
    send_packet(CODE_MOVE, 8'd0);
    send_packet(CODE_MOVE, 8'hFF);
  endtask

  // dead band, lowest live speed, full scale and clamp
  task automatic test_throttle_limits();
    send_packet(CODE_SPEED, 8'd39);
    send_packet(CODE_MOVE, 8'(1 << MOVE_BIT_FWD));
    send_packet(CODE_SPEED, 8'd40);
    send_packet(CODE_MOVE, 8'(1 << MOVE_BIT_REV));
    send_packet(CODE_SPEED, 8'd100);
    send_packet(CODE_MOVE, 8'(1 << MOVE_BIT_FWD));
    send_packet(CODE_SPEED, 8'd255);
    send_packet(CODE_MOVE, 8'(1 << MOVE_BIT_FWD));
  endtask

  // gain writes and echo of unknown codes
  task automatic test_regulator_writes();
    send_packet(CODE_GAIN_P, 8'hFF);
    send_packet(CODE_GAIN_I, 8'h00);
    send_packet(CODE_GAIN_D, 8'hAA);
    send_packet(CODE_UNUSED_LOW, 8'h5A);
    send_packet(CODE_UNUSED_HIGH, 8'hA5);
  endtask

  // automatic mode offsets, auto enable, undefined mode byte
  task automatic test_auto_offsets();
    send_packet(CODE_MODE, MODE_AUTO);
    send_packet(CODE_OFFSET, 8'd0);
    send_packet(CODE_STOP, AUTO_START);
    send_packet(CODE_OFFSET, 8'hFF);
    send_packet(CODE_OFFSET, 8'h01);
    send_packet(CODE_STOP, STOP_NOTHING);
    send_packet(CODE_MODE, MODE_UNDEFINED);
    send_packet(CODE_MOVE, 8'(1 << MOVE_BIT_FWD));
    send_packet(CODE_OFFSET, 8'h80);
    send_packet(CODE_MODE, MODE_MANUAL);
  endtask

  // short stop profile: speed 70 gives a 20 ms high phase and no low phase
  task automatic test_stop_profile();
    send_packet(CODE_SPEED, 8'd70);
    send_packet(CODE_STOP, STOP_START);
    send_packet(CODE_MOVE, 8'(1 << MOVE_BIT_FWD));
    repeat (22) send_tick();
  endtask

  // mostly well formed driving sequences with random content, some noise
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    bit          in_tail;
    start = sent_count;
    while (sent_count - start < RANDOM_ITEMS) begin
      in_tail = (sent_count - start >= RANDOM_ITEMS - CALM_TAIL);
      if (in_tail) idle_pct = 0;
      case ($urandom_range(0, 9))
        // stop sequence followed by a run of ticks
        0, 1, 2: begin
          if ($urandom_range(0, 3) != 0) send_packet(CODE_SPEED, 8'($urandom_range(66, 70)));
          else send_packet(CODE_SPEED, 8'($urandom));
          if ($urandom_range(0, 5) != 0) send_packet(CODE_STOP, STOP_START);
          else send_packet(CODE_MODE, MODE_AUTO);
          repeat ($urandom_range(10, 130)) begin
            if ($urandom_range(0, 19) == 0) send_packet(pick_code(), 8'($urandom));
            else send_tick();
          end
        end
        // manual driving
        3, 4: begin
          send_packet(CODE_MODE, ($urandom_range(0, 7) == 0) ? 8'($urandom) : MODE_MANUAL);
          if ($urandom_range(0, 1) != 0) send_packet(CODE_SPEED, 8'($urandom_range(30, 110)));
          else send_packet(CODE_SPEED, 8'($urandom));
          repeat ($urandom_range(2, 8)) begin
            send_packet(CODE_MOVE, 8'($urandom));
            if ($urandom_range(0, 2) == 0) send_tick();
          end
        end
        // automatic driving
        5, 6: begin
          send_packet(CODE_MODE, MODE_AUTO);
          if ($urandom_range(0, 3) != 0) send_packet(CODE_STOP, AUTO_START);
          if ($urandom_range(0, 4) == 0) send_packet(CODE_SPEED, 8'($urandom));
          repeat ($urandom_range(2, 8)) begin
            send_packet(CODE_OFFSET, ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom));
            pick = $urandom_range(0, 9);
            if (pick == 0) send_packet(CODE_STOP, STOP_START);
            else if (pick < 3) send_tick();
          end
        end
        // mixed packets
        7: repeat ($urandom_range(3, 8)) send_packet(pick_code(), 8'($urandom));
        // raw noise
        8: repeat ($urandom_range(3, 10)) send_item(cmd_item_t'(17'($urandom)));
        // drain, then a new idling level outside the calm tail
        default: begin
          wait_drained();
          if (!in_tail) begin
            case ($urandom_range(0, 2))
              0: idle_pct = 0;
              1: idle_pct = 15;
              default: idle_pct = 40;
            endcase
          end
        end
      endcase
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_manual_moves();
    test_throttle_limits();
    test_regulator_writes();
    test_auto_offsets();
    test_stop_profile();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
